FILE: sv/joint_jerk_limited_motion_shaper_defines.svh
// assertion macros for the joint motion shaper
// no dependencies; included by modules that carry assertions
`ifndef JOINT_JERK_LIMITED_MOTION_SHAPER_DEFINES_SVH
`define JOINT_JERK_LIMITED_MOTION_SHAPER_DEFINES_SVH
`ifndef SYNTH
`define JJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JJ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JJ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define JJ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/jjms_pkg.sv
// shared types, constants and helpers of the joint motion shaper
// no dependencies
package jjms_pkg;

    localparam int LEG_COUNT_DEF = 6;
    localparam int JOINTS_PER_LEG = 3;
    localparam int LIMIT_W = 21;
    localparam int CFG_DATA_W = 63;
    localparam int CFG_ADDR_W = 3;
    localparam logic [16:0] UNITY = 17'd65536;

    localparam logic [CFG_ADDR_W-1:0] REG_VEL_LIM = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACC_LIM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_JERK_LIM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VEL_GAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACC_GAIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_RATE = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UP_V,
        ST_UP_VF,
        ST_UP_A,
        ST_UP_AF,
        ST_LM_V,
        ST_LM_A,
        ST_LM_J,
        ST_LM_LA,
        ST_LM_LV,
        ST_LM_ANG,
        ST_WRITE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   read;
        state_t step;
        logic   commit;
        logic   out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_range;
        logic op_update;
        logic was_valid;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // divide by 65536 rounding half away from zero, saturate
    function automatic logic signed [31:0] round_q16(input logic signed [65:0] p);
        logic        neg;
        logic [65:0] m;
        logic signed [66:0] r;
        neg = p[65];
        m = neg ? 66'(-p) : 66'(p);
        m = (m + 66'd32768) >> 16;
        r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return sat32(r[65:0]);
    endfunction

endpackage

FILE: sv/jjms_ctrl.sv
// controller state machine of the joint motion shaper
// depends on jjms_pkg and the assertion header
`include "joint_jerk_limited_motion_shaper_defines.svh"
module jjms_ctrl
    import jjms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_fire,
    input  logic  out_full,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.step = state_reg;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_fire;
                if (in_fire) state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
                if (!stat.in_range) state_next = ST_OUT;
                else if (stat.op_update)
                    state_next = stat.was_valid ? ST_UP_V : ST_WRITE;
                else
                    state_next = stat.was_valid ? ST_LM_V : ST_OUT;
            end
            ST_UP_V:   state_next = ST_UP_VF;
            ST_UP_VF:  state_next = ST_UP_A;
            ST_UP_A:   state_next = ST_UP_AF;
            ST_UP_AF:  state_next = ST_WRITE;
            ST_LM_V:   state_next = ST_LM_A;
            ST_LM_A:   state_next = ST_LM_J;
            ST_LM_J:   state_next = ST_LM_LA;
            ST_LM_LA:  state_next = ST_LM_LV;
            ST_LM_LV:  state_next = ST_LM_ANG;
            ST_LM_ANG: state_next = ST_OUT;
            ST_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_full || out_fire)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `JJ_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_reg == ST_IDLE)
    `JJ_ASSERT_NXT(a_out_to_idle, clk, rst_n, cmd.out_load, state_reg == ST_IDLE)
    `JJ_ASSERT_NXT(a_commit_out, clk, rst_n, cmd.commit, state_reg == ST_OUT)

endmodule

FILE: sv/jjms_datapath.sv
// datapath of the joint motion shaper: state arrays, one multiply step per cycle
// depends on jjms_pkg
module jjms_datapath
    import jjms_pkg::*;
#(
    parameter int LEG_COUNT = LEG_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic                     operation,
    input  logic [2:0]               leg_index,
    input  logic [1:0]               joint_index,
    input  logic signed [31:0]       angle,
    input  logic [62:0]              vel_lim,
    input  logic [62:0]              acc_lim,
    input  logic [62:0]              jerk_lim,
    input  logic [16:0]              vel_gain,
    input  logic [16:0]              acc_gain,
    input  logic [16:0]              time_step,
    input  logic [31:0]              step_rate,
    output logic signed [31:0]       res,
    output logic                     pass,
    output logic signed [31:0]       vel_out,
    output logic signed [31:0]       acc_out
);

    localparam int JT = LEG_COUNT * JOINTS_PER_LEG;
    localparam int KW = (JT > 1) ? $clog2(JT) : 1;

    logic signed [31:0] ang_mem [JT];
    logic signed [31:0] vel_mem [JT];
    logic signed [31:0] acc_mem [JT];
    logic [JT-1:0]      valid_reg;

    logic               op_reg, rng_reg, was_reg;
    logic [1:0]         jt_reg;
    logic [KW-1:0]      k_reg;
    logic signed [31:0] a_reg, ang_reg, vel_reg, acc_reg, t_reg, nv_reg;
    logic signed [31:0] t_next;

    logic [5:0]  k_full;
    logic        rng;
    assign k_full = 6'(leg_index) * 6'(JOINTS_PER_LEG) + 6'(joint_index);
    assign rng = (32'(leg_index) < 32'(LEG_COUNT))
              && (joint_index < 2'(JOINTS_PER_LEG));

    // history flag is looked up while the controller is in the read step
    assign stat.in_range = rng_reg;
    assign stat.op_update = op_reg;
    assign stat.was_valid = valid_reg[k_reg];

    function automatic logic signed [31:0] lim_of(input logic [62:0] p, input logic [1:0] t);
        logic [LIMIT_W-1:0] f;
        f = p[LIMIT_W*t +: LIMIT_W];
        return $signed({3'b0, f, 8'b0});
    endfunction

    function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                  input logic signed [31:0] l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return round_q16(p);
    endfunction

    function automatic logic signed [31:0] smooth(input logic signed [31:0] f,
        input logic signed [31:0] o, input logic [16:0] g);
        logic signed [18:0] gs;
        logic signed [65:0] p;
        gs = (g > UNITY) ? 19'sd65536 : $signed({2'b0, g});
        p = 66'(gs) * 66'(f) + 66'(19'sd65536 - gs) * 66'(o);
        return round_q16(p);
    endfunction

    function automatic logic signed [31:0] subs(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction

    function automatic logic signed [31:0] adds(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    logic signed [32:0] rate_s, ts_s;
    assign rate_s = $signed({1'b0, step_rate});
    assign ts_s = $signed({16'b0, time_step});

    // one operation per step on the temporary register
    always_comb
    begin
        t_next = t_reg;
        unique case (cmd.step)
            ST_UP_V:   t_next = mulq(subs(a_reg, ang_reg), rate_s);
            ST_UP_VF:  t_next = smooth(t_reg, vel_reg, vel_gain);
            ST_UP_A:   t_next = mulq(subs(t_reg, vel_reg), rate_s);
            ST_UP_AF:  t_next = smooth(t_reg, acc_reg, acc_gain);
            ST_LM_V:   t_next = mulq(subs(a_reg, ang_reg), rate_s);
            ST_LM_A:   t_next = mulq(subs(t_reg, vel_reg), rate_s);
            ST_LM_J:   t_next = clampv(mulq(subs(t_reg, acc_reg), rate_s),
                                       lim_of(jerk_lim, jt_reg));
            ST_LM_LA:  t_next = clampv(adds(acc_reg, mulq(t_reg, ts_s)),
                                       lim_of(acc_lim, jt_reg));
            ST_LM_LV:  t_next = clampv(adds(vel_reg, mulq(t_reg, ts_s)),
                                       lim_of(vel_lim, jt_reg));
            ST_LM_ANG: t_next = adds(ang_reg, mulq(t_reg, ts_s));
            default:   t_next = t_reg;
        endcase
    end

    // item registers and sequencing
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            jt_reg <= joint_index;
            a_reg <= angle;
            rng_reg <= rng;
            k_reg <= rng ? k_full[KW-1:0] : '0;
        end
        if (cmd.read)
        begin
            ang_reg <= ang_mem[k_reg];
            vel_reg <= valid_reg[k_reg] ? vel_mem[k_reg] : 32'sd0;
            acc_reg <= valid_reg[k_reg] ? acc_mem[k_reg] : 32'sd0;
            was_reg <= valid_reg[k_reg];
        end
        t_reg <= t_next;
        if (cmd.step == ST_UP_VF) nv_reg <= t_next;
        if (cmd.commit)
        begin
            ang_mem[k_reg] <= a_reg;
            vel_mem[k_reg] <= was_reg ? nv_reg : 32'sd0;
            acc_mem[k_reg] <= was_reg ? t_reg : 32'sd0;
        end
    end

    // per-joint valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.commit)
            valid_reg[k_reg] <= 1'b1;
    end

    // result selection
    always_comb
    begin
        res = a_reg;
        pass = 1'b1;
        vel_out = 32'sd0;
        acc_out = 32'sd0;
        if (rng_reg)
        begin
            vel_out = vel_reg;
            acc_out = acc_reg;
            if (was_reg)
            begin
                pass = 1'b0;
                if (op_reg)
                begin
                    vel_out = nv_reg;
                    acc_out = t_reg;
                end
                else
                    res = t_reg;
            end
            else if (op_reg)
            begin
                vel_out = 32'sd0;
                acc_out = 32'sd0;
            end
        end
    end

endmodule

FILE: sv/joint_jerk_limited_motion_shaper.sv
// top level of the joint motion shaper: config registers, output register
// depends on jjms_pkg, jjms_ctrl and jjms_datapath
//
// usage:
//   input channel (in_valid/in_ready) carries one transaction per item:
//   operation, leg_index, joint_index, angle. output channel
//   (out_valid/out_ready) returns one result transaction per item.
//   one item in flight at a time. an accepted item passes the read step; a
//   limit item on a joint with history runs the velocity, acceleration,
//   jerk, limited acceleration, velocity and angle steps, an update with
//   history the velocity, acceleration, filter and write steps, a first
//   update only the write step, a pass-through or out-of-range item none;
//   the output step loads the result; out_valid rises as in_ready returns.
//   configuration: cfg_we/cfg_index/cfg_data write a register; the user
//   must write only while idle, the block itself does not enforce it. reset
//   clears all joint history and loads the register defaults. if the
//   receiver stalls, the result waits in the output register and the block
//   finishes the next item but holds it until the slot frees.
module joint_jerk_limited_motion_shaper
    import jjms_pkg::*;
#(
    parameter int LEG_COUNT = LEG_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [2:0]            leg_index,
    input  logic [1:0]            joint_index,
    input  logic signed [31:0]    angle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    shaped_angle,
    output logic                  passed_through,
    output logic signed [31:0]    joint_velocity,
    output logic signed [31:0]    joint_acceleration
);

    logic [62:0] vel_lim_reg, acc_lim_reg, jerk_lim_reg;
    logic [16:0] vel_gain_reg, acc_gain_reg, time_step_reg;
    logic [31:0] step_rate_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  busy, in_fire, out_fire;
    logic signed [31:0] res, vo, ao;
    logic  pass;

    assign in_ready = !busy;
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_lim_reg <= '0;
            acc_lim_reg <= '0;
            jerk_lim_reg <= '0;
            vel_gain_reg <= UNITY;
            acc_gain_reg <= UNITY;
            time_step_reg <= 17'd655;
            step_rate_reg <= 32'd6553600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VEL_LIM:   vel_lim_reg <= cfg_data;
                REG_ACC_LIM:   acc_lim_reg <= cfg_data;
                REG_JERK_LIM:  jerk_lim_reg <= cfg_data;
                REG_VEL_GAIN:  vel_gain_reg <= cfg_data[16:0];
                REG_ACC_GAIN:  acc_gain_reg <= cfg_data[16:0];
                REG_TIME_STEP: time_step_reg <= cfg_data[16:0];
                REG_STEP_RATE: step_rate_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    jjms_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .out_full(out_valid), .stat(stat), .busy(busy), .cmd(cmd)
    );

    jjms_datapath #(.LEG_COUNT(LEG_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .operation(operation), .leg_index(leg_index), .joint_index(joint_index),
        .angle(angle), .vel_lim(vel_lim_reg), .acc_lim(acc_lim_reg),
        .jerk_lim(jerk_lim_reg), .vel_gain(vel_gain_reg), .acc_gain(acc_gain_reg),
        .time_step(time_step_reg), .step_rate(step_rate_reg),
        .res(res), .pass(pass), .vel_out(vo), .acc_out(ao)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_fire)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            shaped_angle <= res;
            passed_through <= pass;
            joint_velocity <= vo;
            joint_acceleration <= ao;
        end
    end

endmodule
